### rtl/tep_pkg.sv
`timescale 1ns / 1ps
package tep_pkg;

  typedef enum logic [5:0] {
    CMD_PRINT = 6'd0, CMD_BELL = 6'd1, CMD_BS = 6'd2, CMD_TAB = 6'd3, CMD_LF = 6'd4,
    CMD_CR = 6'd5, CMD_INDEX = 6'd6, CMD_NEXTLINE = 6'd7, CMD_REVLF = 6'd8,
    CMD_ICH = 6'd9, CMD_CUU = 6'd10, CMD_CUD = 6'd11, CMD_CUF = 6'd12, CMD_CUB = 6'd13,
    CMD_COLUMN = 6'd14, CMD_LINE = 6'd15, CMD_HOME = 6'd16, CMD_MOVE = 6'd17,
    CMD_ED = 6'd18, CMD_EL = 6'd19, CMD_IL = 6'd20, CMD_DL = 6'd21, CMD_DCH = 6'd22,
    CMD_DA1 = 6'd23, CMD_DA2 = 6'd24, CMD_SETMODE = 6'd25, CMD_RESETMODE = 6'd26,
    CMD_SGR = 6'd27, CMD_REGION = 6'd28, CMD_CHARSET = 6'd29, CMD_FILL = 6'd30,
    CMD_TITLEBYTE = 6'd31, CMD_TITLEEND = 6'd32
  } cmd_t;

  typedef enum logic [2:0] {
    PS_PLAIN, PS_ESC, PS_CSI, PS_OSC, PS_CHARSET, PS_PCT, PS_FILL
  } parse_state_t;

  typedef enum logic [2:0] {
    TS_NONE, TS_BOTH, TS_ICON, TS_WINDOW, TS_OTHER
  } title_state_t;

  // back end job kinds
  typedef enum logic [1:0] {
    JOB_SINGLE, // one fixed command
    JOB_LIST,   // one command per numeric parameter
    JOB_REGION  // region then home, or home alone
  } job_kind_t;

  localparam int MAX_OUT = 8;

  function automatic logic [4:0] charset_index(input logic [7:0] c, output logic ok);
    begin
      ok = 1'b1;
      case (c)
        8'h30: charset_index = 5'd0;
        8'h41: charset_index = 5'd1;
        8'h42: charset_index = 5'd2;
        8'h34: charset_index = 5'd3;
        8'h43, 8'h35: charset_index = 5'd4;
        8'h52: charset_index = 5'd5;
        8'h51: charset_index = 5'd6;
        8'h4B: charset_index = 5'd7;
        8'h59: charset_index = 5'd8;
        8'h45, 8'h36: charset_index = 5'd9;
        8'h5A: charset_index = 5'd10;
        8'h48, 8'h37: charset_index = 5'd11;
        8'h3D: charset_index = 5'd12;
        default: begin
          charset_index = 5'd0;
          ok = 1'b0;
        end
      endcase
    end
  endfunction

endpackage

### rtl/tep_front.sv
`timescale 1ns / 1ps
// Front end: parse state, digit accumulation and sequence classification.
// A byte ending a command becomes one job word in the queue. Parameters are
// snapshotted into the job so the back end owns them while draining.
module tep_front import tep_pkg::*; #(
  parameter int MAX_PARAMS = 8,
  parameter int CW = $clog2(MAX_PARAMS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [7:0]                   in_byte,
  input  logic                         q_full,
  output logic                         job_push,
  output job_kind_t                    job_kind,
  output cmd_t                         job_cmd,
  output logic [15:0]                  job_a,
  output logic [15:0]                  job_b,
  output logic                         job_two,
  output logic [MAX_PARAMS-1:0][16:0]  job_params,
  output logic [CW-1:0]                job_count
);

  parse_state_t               pstate, pstate_next;
  title_state_t               tstate, tstate_next;
  logic [MAX_PARAMS-1:0][16:0] params, params_next;
  logic [CW-1:0]              count, count_next;
  logic [16:0]                acc, acc_next;
  logic                       digits, digits_next;
  logic                       inter, inter_next;
  logic                       priv, priv_next;
  logic                       in_take;

  assign in_take = in_valid && !q_full;

  // combinational sequence handling
  always_comb begin
    logic [7:0]  c;
    logic [20:0] prod;
    logic        ok;
    logic [4:0]  csx;
    logic [16:0] p0, p1;
    logic [15:0] n0, n0d, n1;
    logic        m0, clear, emit;
    c = in_byte;
    pstate_next = pstate;
    tstate_next = tstate;
    params_next = params;
    count_next = count;
    acc_next = acc;
    digits_next = digits;
    inter_next = inter;
    priv_next = priv;
    clear = 1'b0;
    emit = 1'b0;
    job_kind = JOB_SINGLE;
    job_cmd = CMD_PRINT;
    job_a = 16'd0;
    job_b = 16'd0;
    job_two = 1'b0;
    prod = 21'd0;
    ok = 1'b0;
    csx = 5'd0;

    // parameter bytes and number closing shared by CSI and OSC
    if ((pstate == PS_CSI || (pstate == PS_OSC && count == '0 && tstate == TS_NONE))
        && c >= 8'h30 && c <= 8'h3F) begin
      if (c <= 8'h39) begin
        prod = {4'd0, acc} * 21'd10 + {17'd0, c[3:0]};
        acc_next = (prod > 21'd65535) ? 17'h10000 : prod[16:0];
        digits_next = 1'b1;
      end else if (c == 8'h3B || (c == 8'h3F && !(count == '0 && !digits))
                   || (c >= 8'h3C && c <= 8'h3E)) begin
        acc_next = 17'd0;
        digits_next = 1'b0;
        if (digits && count < CW'(MAX_PARAMS)) begin
          for (int k = 0; k < MAX_PARAMS; k++)
            if (count == CW'(k)) params_next[k] = acc[16] ? 17'd0 : acc;
          count_next = count + CW'(1);
        end
        if (c >= 8'h3C && c <= 8'h3E && count_next < CW'(MAX_PARAMS)) begin
          for (int k = 0; k < MAX_PARAMS; k++)
            if (count_next == CW'(k)) params_next[k] = {1'b1, 8'd0, c};
          count_next = count_next + CW'(1);
        end
      end else if (c == 8'h3F) begin
        priv_next = 1'b1;
      end
    end else if (pstate == PS_CSI || pstate == PS_OSC) begin
      acc_next = 17'd0;
      digits_next = 1'b0;
      if (digits && count < CW'(MAX_PARAMS)) begin
        for (int k = 0; k < MAX_PARAMS; k++)
          if (count == CW'(k)) params_next[k] = acc[16] ? 17'd0 : acc;
        count_next = count + CW'(1);
      end
    end

    p0 = params_next[0];
    p1 = params_next[1 % MAX_PARAMS];
    m0 = (count_next != '0) && p0[16];
    n0 = (count_next == '0) ? 16'd1 : (p0[16] ? 16'd0 : p0[15:0]);
    n0d = (count_next == '0) ? 16'd0 : (p0[16] ? 16'd0 : p0[15:0]);
    n1 = (count_next < CW'(2)) ? 16'd0 : (p1[16] ? 16'd0 : p1[15:0]);

    case (pstate)
      PS_PLAIN: begin
        emit = 1'b1;
        if (c >= 8'h20) begin
          job_a = {8'd0, c};
        end else if (c == 8'h07) job_cmd = CMD_BELL;
        else if (c == 8'h08) job_cmd = CMD_BS;
        else if (c == 8'h09) job_cmd = CMD_TAB;
        else if (c == 8'h0A) job_cmd = CMD_LF;
        else if (c == 8'h0D) job_cmd = CMD_CR;
        else begin
          emit = 1'b0;
          if (c == 8'h1B) pstate_next = PS_ESC;
        end
      end
      PS_ESC: begin
        clear = 1'b1;
        emit = 1'b1;
        if (c == 8'h44) job_cmd = CMD_INDEX;
        else if (c == 8'h45) job_cmd = CMD_NEXTLINE;
        else if (c == 8'h4D) job_cmd = CMD_REVLF;
        else emit = 1'b0;
      end
      PS_CSI: begin
        if (c >= 8'h20 && c <= 8'h2F) inter_next = 1'b1;
        else if (c >= 8'h40 && c <= 8'h7D) begin
          clear = 1'b1;
          if (!inter) begin
            emit = 1'b1;
            case (c)
              8'h40: begin job_cmd = CMD_ICH; job_a = n0; end
              8'h41: begin job_cmd = CMD_CUU; job_a = n0; end
              8'h42: begin job_cmd = CMD_CUD; job_a = (n0 == 16'd0) ? 16'd1 : n0; end
              8'h43: begin job_cmd = CMD_CUF; job_a = n0; end
              8'h44: begin job_cmd = CMD_CUB; job_a = n0; end
              8'h47: begin job_cmd = CMD_COLUMN; job_a = n0; end
              8'h64: begin job_cmd = CMD_LINE; job_a = n0; end
              8'h4C: begin job_cmd = CMD_IL; job_a = n0; end
              8'h4D: begin job_cmd = CMD_DL; job_a = n0; end
              8'h50: begin job_cmd = CMD_DCH; job_a = n0; end
              8'h48, 8'h66: begin
                if (count_next == '0) job_cmd = CMD_HOME;
                else if (count_next == CW'(2)) begin
                  job_cmd = CMD_MOVE; job_a = n1; job_b = n0d;
                end else emit = 1'b0;
              end
              8'h4A, 8'h4B: begin
                job_cmd = (c == 8'h4A) ? CMD_ED : CMD_EL;
                job_a = n0d;
                if (m0 || n0d > 16'd2) emit = 1'b0;
              end
              8'h63: job_cmd = (count_next != '0 && p0 == 17'h1003E) ? CMD_DA2 : CMD_DA1;
              8'h68, 8'h6C: begin
                job_kind = JOB_LIST;
                job_cmd = (c == 8'h68) ? CMD_SETMODE : CMD_RESETMODE;
                job_b = {15'd0, priv};
              end
              8'h6D: begin
                job_cmd = CMD_SGR;
                if (count_next != '0) job_kind = JOB_LIST;
              end
              8'h72: begin
                job_kind = JOB_REGION;
                job_cmd = CMD_REGION;
                if (count_next == CW'(2)) begin
                  job_a = p0[15:0]; job_b = n1; job_two = !p0[16];
                end else begin
                  job_a = 16'd1; job_two = 1'b1;
                end
              end
              default: emit = 1'b0;
            endcase
          end
        end
      end
      PS_OSC: begin
        if (!(count == '0 && tstate == TS_NONE && c >= 8'h30 && c <= 8'h3F)) begin
          if (tstate == TS_NONE) begin
            if (count_next != CW'(1)) clear = 1'b1;
            else if (p0 == 17'd0) tstate_next = TS_BOTH;
            else if (p0 == 17'd1) tstate_next = TS_ICON;
            else if (p0 == 17'd2) tstate_next = TS_WINDOW;
            else tstate_next = TS_OTHER;
          end
          if (!clear) begin
            if (c == 8'h07) begin
              clear = 1'b1;
              if (tstate_next == TS_BOTH || tstate_next == TS_WINDOW) begin
                emit = 1'b1; job_cmd = CMD_TITLEEND;
              end
            end else if (tstate_next == TS_BOTH || tstate_next == TS_WINDOW) begin
              emit = 1'b1; job_cmd = CMD_TITLEBYTE; job_a = {8'd0, c};
            end
          end
        end
      end
      PS_CHARSET: begin
        clear = 1'b1;
        csx = charset_index(c, ok);
        emit = ok;
        job_cmd = CMD_CHARSET;
        job_a = {11'd0, csx};
      end
      PS_FILL: begin
        clear = 1'b1;
        emit = (c == 8'h38);
        job_cmd = CMD_FILL;
        job_a = 16'h0045;
      end
      default: clear = 1'b1;
    endcase

    job_params = params_next;
    job_count = count_next;
    job_push = in_take && emit;

    if (clear) begin
      tstate_next = TS_NONE;
      count_next = '0;
      acc_next = 17'd0;
      digits_next = 1'b0;
      inter_next = 1'b0;
      priv_next = 1'b0;
      pstate_next = PS_PLAIN;
      if (pstate == PS_ESC) begin
        if (c == 8'h5B) pstate_next = PS_CSI;
        else if (c == 8'h5D) pstate_next = PS_OSC;
        else if (c == 8'h23) pstate_next = PS_FILL;
        else if (c == 8'h28) pstate_next = PS_CHARSET;
        else if (c == 8'h25) pstate_next = PS_PCT;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= PS_PLAIN;
      tstate <= TS_NONE;
      count <= '0;
      acc <= 17'd0;
      digits <= 1'b0;
      inter <= 1'b0;
      priv <= 1'b0;
    end else if (in_take) begin
      pstate <= pstate_next;
      tstate <= tstate_next;
      count <= count_next;
      acc <= acc_next;
      digits <= digits_next;
      inter <= inter_next;
      priv <= priv_next;
    end
  end

  // parameter store, no reset
  always_ff @(posedge clk) begin
    if (in_take) params <= params_next;
  end

endmodule

### rtl/tep_back.sv
`timescale 1ns / 1ps
// Back end: pops jobs from a two-entry queue and expands them into commands.
// List jobs step through the stored parameters in order, skipping markers; at most eight words per job.
module tep_back import tep_pkg::*; #(
  parameter int MAX_PARAMS = 8,
  parameter int CW = $clog2(MAX_PARAMS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   screen_rows,
  input  logic                         job_push,
  input  job_kind_t                    job_kind,
  input  cmd_t                         job_cmd,
  input  logic [15:0]                  job_a,
  input  logic [15:0]                  job_b,
  input  logic                         job_two,
  input  logic [MAX_PARAMS-1:0][16:0]  job_params,
  input  logic [CW-1:0]                job_count,
  output logic                         q_full,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [5:0]                   command,
  output logic [15:0]                  arg_first,
  output logic [15:0]                  arg_second,
  output logic                         last
);

  typedef struct packed {
    job_kind_t                   kind;
    cmd_t                        cmd;
    logic [15:0]                 a;
    logic [15:0]                 b;
    logic                        two;
    logic [MAX_PARAMS-1:0][16:0] params;
    logic [CW-1:0]               count;
  } job_t;

  job_t       q [2];
  logic       wp, rp;
  logic [1:0] fill;
  job_t       cur;
  logic       busy;
  logic [CW-1:0] idx;
  logic [3:0] nout;
  logic       pop, adv, fin;
  logic       have;
  logic [5:0] w_cmd;
  logic [15:0] w_a, w_b;
  logic       w_last;

  assign q_full = (fill == 2'd2);
  assign adv = !out_valid || !out_stall;
  assign pop = !busy && fill != 2'd0;

  // next word of the current job
  always_comb begin
    logic [CW-1:0] nx;
    logic          more;
    logic [16:0]   p;
    have = 1'b0;
    fin = 1'b0;
    w_cmd = cur.cmd;
    w_a = cur.a;
    w_b = cur.b;
    w_last = 1'b0;
    more = 1'b0;
    p = 17'd0;
    for (int k = 0; k < MAX_PARAMS; k++)
      if (idx == CW'(k)) p = cur.params[k];
    case (cur.kind)
      JOB_LIST: begin
        have = (idx < cur.count) && !p[16];
        w_a = p[15:0];
        for (int k = 0; k < MAX_PARAMS; k++) begin
          nx = CW'(k);
          if (nx > idx && nx < cur.count && !cur.params[k][16]) more = 1'b1;
        end
        fin = !more || (have && nout == 4'd7);
        w_last = fin;
      end
      JOB_REGION: begin
        have = 1'b1;
        if (idx == '0 && cur.two) begin
          w_b = (cur.count == CW'(2)) ? cur.b : {8'd0, screen_rows};
        end else begin
          w_cmd = CMD_HOME; w_a = 16'd0; w_b = 16'd0;
          w_last = 1'b1;
          fin = 1'b1;
        end
      end
      JOB_SINGLE: begin
        have = 1'b1; w_last = 1'b1; fin = 1'b1;
      end
      default: fin = 1'b1;
    endcase
  end

  // queue, job walker and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
      busy <= 1'b0; idx <= '0; nout <= 4'd0; out_valid <= 1'b0;
    end else begin
      if (job_push) begin
        q[wp] <= '{job_kind, job_cmd, job_a, job_b, job_two, job_params, job_count};
        wp <= !wp;
      end
      fill <= fill + {1'b0, job_push} - {1'b0, pop};
      if (adv) out_valid <= !pop && busy && have;
      if (pop) begin
        cur <= q[rp]; rp <= !rp; busy <= 1'b1; idx <= '0; nout <= 4'd0;
      end else if (busy && adv) begin
        if (have) begin
          command <= w_cmd; arg_first <= w_a; arg_second <= w_b; last <= w_last;
          nout <= nout + 4'd1;
        end
        if ((have && fin) || (cur.kind == JOB_LIST && idx >= cur.count)) busy <= 1'b0;
        else if (cur.kind == JOB_LIST && !have && !fin) idx <= idx + CW'(1);
        else if (cur.kind == JOB_LIST && !have && fin) busy <= 1'b0;
        else idx <= idx + CW'(1);
      end
    end
  end

endmodule

### rtl/terminal_escape_parser_top.sv
`timescale 1ns / 1ps
// With the expander idle, a byte's first command goes through the queue pop, then
// the output register. Bytes with no command push no job into the queue.
// Throughput: one command word per cycle within a job while out_stall is low and
// no marker parameter is skipped; list commands (sgr, set/reset mode) give one
// word per stored numeric parameter.
// Reset: synchronous rst returns to plain text, empties the queue, rows 24.
module terminal_escape_parser_top import tep_pkg::*; #(
  parameter int MAX_PARAMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  command,
  output logic [15:0] arg_first,
  output logic [15:0] arg_second,
  output logic        last
);

  localparam int CW = $clog2(MAX_PARAMS + 1);

  logic [7:0] screen_rows;
  logic       q_full, job_push, job_two;
  job_kind_t  job_kind;
  cmd_t       job_cmd;
  logic [15:0] job_a, job_b;
  logic [MAX_PARAMS-1:0][16:0] job_params;
  logic [CW-1:0] job_count;

  always_ff @(posedge clk) begin
    if (rst) screen_rows <= 8'd24;
    else if (cfg_we) screen_rows <= cfg_wdata;
  end

  assign in_stall = q_full;

  tep_front #(.MAX_PARAMS(MAX_PARAMS), .CW(CW)) u_front (
    .clk, .rst, .in_valid, .in_byte(byte_in), .q_full,
    .job_push, .job_kind, .job_cmd, .job_a, .job_b, .job_two, .job_params,
    .job_count
  );

  tep_back #(.MAX_PARAMS(MAX_PARAMS), .CW(CW)) u_back (
    .clk, .rst, .screen_rows, .job_push, .job_kind, .job_cmd, .job_a, .job_b,
    .job_two, .job_params, .job_count, .q_full, .out_valid, .out_stall,
    .command, .arg_first, .arg_second, .last
  );

endmodule

### rtl/tep_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the output word stream.
module tep_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  command,
  input logic [15:0] arg_first,
  input logic        last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command) && $stable(arg_first))
    else $error("stalled word changed");

  // command codes stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command <= 6'd32)
    else $error("bad command code");

  // print and bell are always single words
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == 6'd0 || command == 6'd1) |-> last)
    else $error("single command not last");

  // region is always followed by more
  a_region: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == 6'd28 |-> !last)
    else $error("region marked last");

endmodule

bind terminal_escape_parser_top tep_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .command, .arg_first, .last
);
